FILE: hw/rtl/radio_frame_xor_chain_codec_macros.svh
// assertion macros for the radio frame xor chain codec
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef RADIO_FRAME_XOR_CHAIN_CODEC_MACROS_SVH
`define RADIO_FRAME_XOR_CHAIN_CODEC_MACROS_SVH

// condition implies consequence in the same cycle
`define RFXC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rfxc assertion failed");

// condition implies a delayed consequence
`define RFXC_ASSERT_DLY2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("rfxc delayed assertion failed");

`endif

FILE: hw/rtl/rfxc_pkg.sv
// shared types and constants for the radio frame xor chain codec
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rfxc_pkg;

  localparam int MaxFrame   = 64;  // lengths at or above this are rejected, 4..128
  localparam int LenW       = 7;
  localparam int QueueDepth = 2;   // power of two
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0] FirstMask = 8'h89;
  localparam logic [7:0] ChainAdd  = 8'hdc;
  localparam logic [6:0] LenMask   = 7'h7f;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       frame_last;
    logic       length_error;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_FIRST,
    KIND_MID,
    KIND_MID_CTRL,
    KIND_ZERO,
    KIND_FINAL
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       enc;
    logic       last;
    logic       err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/radio_frame_xor_chain_codec.sv
// Radio frame xor chain whitening codec, one byte per transaction.
// Input channel (in_valid_i / in_stall_o / in_data_i): frame bytes, the
// length byte marked by frame_start. Output channel (out_valid_o /
// out_stall_i / out_data_o): one coded byte per length byte and per byte
// inside an open frame; bytes outside a frame give no transaction.
// cfg_we_i writes cfg_data_i into the mode bit (0 decode, 1 encode).
// A result passes the command queue and then the output register before
// it shows on out_valid_o. Throughput: one byte per cycle when nothing stalls,
// held by the combinational add and xor against the previous scrambled byte.
// A two-entry command queue parts the front end from the output register;
// in_stall_o rises only when that queue is full, so a stalled receiver
// backs up first the output register, then the queue, then the sender.
// Reset clears the mode to decode, closes any open frame and empties the
// queue and output register.
// Depends on rfxc_pkg, rfxc_front, rfxc_queue, rfxc_back and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "radio_frame_xor_chain_codec_macros.svh"

module radio_frame_xor_chain_codec (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rfxc_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rfxc_pkg::out_item_t      out_data_o
);
  import rfxc_pkg::*;

  cmd_t      push_cmd, head_cmd;
  logic      push, pop;
  q_status_t q_stat;

  rfxc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rfxc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  rfxc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `RFXC_ASSERT_IMPL(a_err_is_last, out_valid_o && out_data_o.length_error, out_data_o.frame_last)
  `RFXC_ASSERT_IMPL(a_err_len, out_valid_o && out_data_o.length_error, out_data_o.coded_byte >= 8'(MaxFrame))
  `RFXC_ASSERT_DLY2(a_start_latency, in_valid_i && !in_stall_o && in_data_i.frame_start && q_stat.empty && (!out_valid_o || !out_stall_i), out_valid_o)

endmodule

`default_nettype wire

FILE: hw/rtl/rfxc_front.sv
// front end: mode register, frame tracking and byte classification
// depends on rfxc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfxc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rfxc_pkg::in_item_t in_data_i,
  input  wire rfxc_pkg::q_status_t q_stat_i,
  output logic                   push_o,
  output rfxc_pkg::cmd_t         cmd_o
);
  import rfxc_pkg::*;

  logic            enc_q;
  logic            in_frame_q, in_frame_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [7:0]      len_byte;
  logic [LenW-1:0] pos_n;
  logic            accept, is_last, too_long;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    len_byte   = enc_q ? in_data_i.frame_byte : {1'b0, in_data_i.frame_byte[6:0]};
    too_long   = (len_byte >= 8'(MaxFrame));
    pos_n      = pos_q + LenW'(1);
    is_last    = (pos_n >= len_q);
    in_frame_d = in_frame_q;
    len_d      = len_q;
    pos_d      = pos_q;
    push_o     = 1'b0;
    cmd_o.kind = KIND_PASS;
    cmd_o.data = in_data_i.frame_byte;
    cmd_o.enc  = enc_q;
    cmd_o.last = 1'b0;
    cmd_o.err  = 1'b0;
    if (accept) begin
      if (in_data_i.frame_start) begin
        push_o     = 1'b1;
        cmd_o.data = len_byte;
        if (too_long) begin
          in_frame_d = 1'b0;
          cmd_o.last = 1'b1;
          cmd_o.err  = 1'b1;
        end else begin
          len_d      = len_byte[LenW-1:0] & LenMask;
          pos_d      = '0;
          in_frame_d = (len_byte != 8'd0);
          cmd_o.last = (len_byte == 8'd0);
        end
      end else if (in_frame_q) begin
        push_o     = 1'b1;
        pos_d      = pos_n;
        cmd_o.last = is_last;
        if (is_last) in_frame_d = 1'b0;
        priority if (pos_n == LenW'(1)) begin
          cmd_o.kind = KIND_FIRST;
        end else if (!is_last) begin
          cmd_o.kind = (pos_n == LenW'(2)) ? KIND_MID_CTRL : KIND_MID;
        end else if (len_q == LenW'(2)) begin
          cmd_o.kind = KIND_ZERO;
        end else begin
          cmd_o.kind = KIND_FINAL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q      <= 1'b0;
      in_frame_q <= 1'b0;
      len_q      <= '0;
      pos_q      <= '0;
    end else begin
      if (cfg_we_i) enc_q <= cfg_data_i;
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rfxc_queue.sv
// short command queue between front and back end
// depends on rfxc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfxc_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire rfxc_pkg::cmd_t      cmd_i,
  input  wire logic                pop_i,
  output rfxc_pkg::cmd_t           cmd_o,
  output rfxc_pkg::q_status_t      stat_o
);
  import rfxc_pkg::*;

  cmd_t            mem [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PtrW'(1);
      if (do_pop)  rd_q <= rd_q + PtrW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rfxc_back.sv
// back end: xor chain arithmetic and output register
// depends on rfxc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfxc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rfxc_pkg::cmd_t      cmd_i,
  input  wire rfxc_pkg::q_status_t q_stat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rfxc_pkg::out_item_t      out_data_o
);
  import rfxc_pkg::*;

  logic       out_valid_q;
  out_item_t  out_data_q;
  logic [7:0] prev_q, prev_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] res;

  assign pop_o       = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    prev_d = prev_q;
    ctrl_d = ctrl_q;
    unique case (cmd_i.kind)
      KIND_PASS:  res = cmd_i.data;
      KIND_FIRST: begin
        res    = ~cmd_i.data ^ FirstMask;
        prev_d = cmd_i.enc ? res : cmd_i.data;
      end
      KIND_MID, KIND_MID_CTRL: begin
        res    = (prev_q + ChainAdd) ^ cmd_i.data;
        prev_d = cmd_i.enc ? res : cmd_i.data;
        // plain byte 2 keys the final byte
        if (cmd_i.kind == KIND_MID_CTRL) ctrl_d = cmd_i.enc ? cmd_i.data : res;
      end
      KIND_ZERO:  res = 8'd0;
      KIND_FINAL: res = cmd_i.data ^ ctrl_q;
      default:    res = cmd_i.data;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q.coded_byte   <= res;
      out_data_q.frame_last   <= cmd_i.last;
      out_data_q.length_error <= cmd_i.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      ctrl_q      <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        prev_q      <= prev_d;
        ctrl_q      <= ctrl_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: test/radio_frame_xor_chain_codec_tb.sv
// self-checking testbench for the radio frame xor chain whitening codec
// predicts every coded byte in a scoreboard class and compares in order
// depends on rfxc_pkg and radio_frame_xor_chain_codec
`timescale 1ns / 1ps

module radio_frame_xor_chain_codec_tb;
  import rfxc_pkg::*;

  localparam bit ModeDecode  = 1'b0;
  localparam bit ModeEncode  = 1'b1;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 60;
  localparam int SettleCycles = 6;
  localparam int HoldCycles  = 90;
  localparam int StuckLimit  = 2000;

  class whitening_scoreboard;
    out_item_t  pending_coded[$];
    bit         encode;
    bit         in_frame;
    logic [6:0] frame_len;
    logic [6:0] position;
    logic [7:0] prev_scrambled;
    logic [7:0] ctrl_plain;
    int         errors;

    function new();
      encode         = ModeDecode;
      in_frame       = 1'b0;
      frame_len      = '0;
      position       = '0;
      prev_scrambled = '0;
      ctrl_plain     = '0;
      errors         = 0;
    endfunction

    function void set_mode(bit m);
      encode = m;
    endfunction

    function int pending();
      return pending_coded.size();
    endfunction

    // works out the coded byte that an accepted input byte causes, if any
    function void note_byte(in_item_t it);
      logic [7:0] b;
      logic [7:0] len;
      logic [7:0] res;
      bit         last;
      b = it.frame_byte;
      if (it.frame_start) begin
        len = encode ? b : {1'b0, b[6:0]};
        if (len >= MaxFrame) begin
          in_frame = 1'b0;
          pending_coded.push_back('{coded_byte: len, frame_last: 1'b1, length_error: 1'b1});
        end else begin
          frame_len = len[6:0];
          position  = '0;
          in_frame  = (len != 0);
          pending_coded.push_back('{coded_byte: len, frame_last: (len == 0),
                                    length_error: 1'b0});
        end
        return;
      end
      if (!in_frame) return;
      position = position + 7'd1;
      last     = (position >= frame_len);
      if (position == 7'd1) begin
        res            = ~b ^ FirstMask;
        prev_scrambled = encode ? res : b;
      end else if (!last) begin
        res            = (prev_scrambled + ChainAdd) ^ b;
        prev_scrambled = encode ? res : b;
        if (position == 7'd2) ctrl_plain = encode ? b : res;
      end else if (frame_len == 7'd2) begin
        res = 8'h00;
      end else begin
        res = b ^ ctrl_plain;
      end
      if (last) in_frame = 1'b0;
      pending_coded.push_back('{coded_byte: res, frame_last: last, length_error: 1'b0});
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      if (errors <= 40)
        $display("%0t mismatch %s: got %02h expected %02h", $realtime, what, got, want);
    endtask

    task check_coded(out_item_t got);
      out_item_t want;
      if (pending_coded.size() == 0) begin
        report_mismatch("unexpected transaction", got.coded_byte, 8'h00);
        return;
      end
      want = pending_coded.pop_front();
      if (got.coded_byte !== want.coded_byte)
        report_mismatch("coded_byte", got.coded_byte, want.coded_byte);
      if (got.frame_last !== want.frame_last)
        report_mismatch("frame_last", {7'd0, got.frame_last}, {7'd0, want.frame_last});
      if (got.length_error !== want.length_error)
        report_mismatch("length_error", {7'd0, got.length_error}, {7'd0, want.length_error});
    endtask
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  whitening_scoreboard sb;
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  bit cur_mode = ModeDecode;
  int stuck_cycles = 0;

  radio_frame_xor_chain_codec uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // monitors and watchdog, sampled before the edge takes effect
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_coded(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{frame_byte: b, frame_start: s};
    do @(posedge clk_i); while (in_stall);
  endtask

  // length byte as the block sees it; bit 7 is masked off in decode mode
  task automatic send_length(input int len);
    logic [7:0] lb;
    lb = len[7:0];
    if (cur_mode == ModeDecode) lb[7] = 1'($urandom_range(0, 1));
    send_byte(lb, 1'b1);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // sender pauses until every expected byte is back and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_mode = m;
    sb.set_mode(m);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 40);
    return $urandom_range(41, MaxFrame - 1);
  endfunction

  task automatic directed_frames();
    send_byte(8'h3c, 1'b0);              // dropped, no frame open
    send_byte(8'hff, 1'b1);              // masked to 7f, too long
    send_byte(8'h40, 1'b1);              // exactly at the limit
    send_byte(8'h80, 1'b1);              // masks to zero length
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);              // single byte frame
    send_byte(8'h02, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h12, 1'b0);              // length two, final comes out zero
    send_byte(8'h05, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h83, 1'b1);              // start inside an open frame
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h04, 1'b1);
    send_byte(8'h5a, 1'b0);
    send_byte(8'hc3, 1'b0);
    drain();
    write_mode(ModeEncode);              // mode flips mid frame
    send_byte(8'h99, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'h80, 1'b1);              // not masked when encoding
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    drain();
  endtask

  task automatic random_transaction(output int counted);
    int         pick;
    int         len;
    int         cut;
    logic [7:0] lb;
    pick = $urandom_range(0, 99);
    counted = 0;
    if (pick < 74) begin
      len = pick_len();
      send_length(len);
      send_payload(len);
      counted = len + 1;
    end else if (pick < 82) begin
      lb = 8'($urandom_range(0, 255));
      lb[6] = 1'b1;
      if (cur_mode == ModeEncode && $urandom_range(0, 1)) lb = 8'($urandom_range(128, 255));
      send_byte(lb, 1'b1);
      counted = 1;
    end else if (pick < 87) begin
      send_length(0);
      counted = 1;
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // frame cut short by the next start, then a clean frame
      len = $urandom_range(3, 12);
      cut = $urandom_range(1, len - 1);
      send_length(len);
      send_payload(cut);
      len = pick_len();
      send_length(len);
      send_payload(len);
      counted = cut + len + 2;
    end
  endtask

  initial begin
    int phase_items;
    int n;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    write_mode(ModeDecode);
    directed_frames();

    for (int p = 0; p < NumPhases; p++) begin
      write_mode((p < 2) ? p[0] : bit'($urandom_range(0, 1)));
      if (p == NumPhases - 1) idle_on = 1'b0;
      if (p == 3) begin
        // long receiver hold against the longest frame
        hold_req = 1'b1;
        send_length(MaxFrame - 1);
        send_payload(MaxFrame - 1);
      end
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        random_transaction(n);
        phase_items += n;
        if ($urandom_range(0, 29) == 0) drain();
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
